FILE: src/eci_pkg.sv
`timescale 1ns / 1ps

package eci_pkg;

    // Curve table geometry.
    localparam int CURVE_TABLE_BITS = 8;
    localparam int TBL_N            = 1 << CURVE_TABLE_BITS;
    localparam int TBL_HALF         = TBL_N / 2;
    localparam int FRAC_SH          = 16 - CURVE_TABLE_BITS;
    localparam int IDX_W            = CURVE_TABLE_BITS + 1;
    localparam int EVEN_W           = CURVE_TABLE_BITS;
    localparam int ODD_W            = CURVE_TABLE_BITS - 1;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int PROG_W  = 17;
    localparam int VAL_W   = 16;
    localparam int EASED_W = 17;
    localparam int DIFF_W  = VAL_W + 1;
    localparam int SQ_OP_W = 21;
    localparam int SQ_W    = 2 * SQ_OP_W;
    localparam int ITP_W   = EASED_W + FRAC_SH + 2;

    localparam logic [PROG_W-1:0]  Q16_ONE    = 17'h10000;
    localparam logic [EASED_W-1:0] EASED_MAX  = 17'd98304;
    localparam logic [ITP_W-1:0]   ITP_HALF   = ITP_W'(1) << (FRAC_SH - 1);
    localparam logic [SQ_W-1:0]    SQ_HALF15  = SQ_W'(1) << 14;
    localparam logic [SQ_W-1:0]    SQ_HALF16  = SQ_W'(1) << 15;
    localparam logic [SQ_W-1:0]    SQ_HALF22  = SQ_W'(1) << 21;

    // Cycles from the curve unit's request register to its result register.
    localparam int CURVE_LAT = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_LINEAR       = 3'd0,
        FN_IN_QUAD      = 3'd1,
        FN_OUT_QUAD     = 3'd2,
        FN_IN_OUT_QUAD  = 3'd3,
        FN_OUT_BOUNCE   = 3'd4,
        FN_IN_OUT_SINE  = 3'd5,
        FN_OUT_ELASTIC  = 3'd6,
        FN_LINEAR_ALT   = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        SH_15,
        SH_16,
        SH_22
    } t_shift;

    typedef enum logic [1:0] {
        K_PASS,
        K_SQ_ADD,
        K_SQ_SUB,
        K_TABLE
    } t_kind;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [PROG_W-1:0]        progress;
        logic signed [VAL_W-1:0]  start_value;
        logic signed [VAL_W-1:0]  target_value;
    } t_in_item;

    typedef struct packed {
        logic [EASED_W-1:0]       eased_factor;
        logic signed [VAL_W-1:0]  blended_value;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [FUNC_W-1:0]  func;
        logic [PROG_W-1:0]  t;
    } t_curve_req;

    typedef struct packed {
        logic               valid;
        logic [EASED_W-1:0] eased;
    } t_curve_rsp;

    // Table build arithmetic, evaluated at elaboration only.
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] SINE_DEN  = 64'(2 * TBL_N);
    localparam logic [63:0] ELAS_DEN  = 64'(12 * TBL_N);
    localparam logic [63:0] NINE_N    = 64'(9 * TBL_N);

    typedef logic [EASED_W-1:0] t_rom_even [0:TBL_HALF];
    typedef logic [EASED_W-1:0] t_rom_odd  [0:TBL_HALF-1];

    // Cosine of 2*pi*num/den in Q30 by a Taylor series through the x^16 term.
    function automatic logic signed [63:0] cos_q30(input logic [63:0] num_in,
                                                   input logic elas);
        logic [63:0]        num;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               neg;
        num = num_in;
        neg = 1'b0;
        if (elas) begin
            if (64'd2 * num > ELAS_DEN) num = ELAS_DEN - num;
            if (64'd4 * num > ELAS_DEN) begin
                num = ELAS_DEN / 2 - num;
                neg = 1'b1;
            end
            x = (num * 64'd2 * PI_Q30 + ELAS_DEN / 2) / ELAS_DEN;
        end else begin
            if (64'd2 * num > SINE_DEN) num = SINE_DEN - num;
            if (64'd4 * num > SINE_DEN) begin
                num = SINE_DEN / 2 - num;
                neg = 1'b1;
            end
            x = (num * 64'd2 * PI_Q30 + SINE_DEN / 2) / SINE_DEN;
        end
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
        return neg ? -sum : sum;
    endfunction

    // exp(-y) in Q30 for 0 <= y <= ln2.
    function automatic logic [63:0] expneg_q30(input logic [63:0] y);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        term = ((term * y) >> 30) / 64'd1;  sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd2;  sum = sum + $signed(term);
        term = ((term * y) >> 30) / 64'd3;  sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd4;  sum = sum + $signed(term);
        term = ((term * y) >> 30) / 64'd5;  sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd6;  sum = sum + $signed(term);
        term = ((term * y) >> 30) / 64'd7;  sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd8;  sum = sum + $signed(term);
        term = ((term * y) >> 30) / 64'd9;  sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd10; sum = sum + $signed(term);
        term = ((term * y) >> 30) / 64'd11; sum = sum - $signed(term);
        term = ((term * y) >> 30) / 64'd12; sum = sum + $signed(term);
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function automatic logic [EASED_W-1:0] clamp_q30(input logic signed [63:0] v);
        logic [63:0] q;
        if (v <= 0) return '0;
        q = (64'(v) + 64'd8192) >> 14;
        if (q > 64'(EASED_MAX)) return EASED_MAX;
        return q[EASED_W-1:0];
    endfunction

    function automatic logic [EASED_W-1:0] sine_entry(input int i);
        logic signed [63:0] c;
        c = cos_q30(64'(i), 1'b0);
        return clamp_q30(($signed(ONE_Q30) - c) / 64'sd2);
    endfunction

    function automatic logic [EASED_W-1:0] elastic_entry(input int i);
        logic [63:0]        a;
        logic [63:0]        kexp;
        logic [63:0]        rem;
        logic [63:0]        y;
        logic [63:0]        e;
        logic [63:0]        p;
        logic signed [63:0] s;
        logic [63:0]        mag;
        logic [63:0]        prod;
        a    = 64'(10 * i);
        kexp = a >> CURVE_TABLE_BITS;
        rem  = a & 64'(TBL_N - 1);
        y    = (rem * LN2_Q30 + 64'(TBL_N / 2)) >> CURVE_TABLE_BITS;
        e    = expneg_q30(y) >> kexp;
        p    = (64'(40 * i) + NINE_N) % ELAS_DEN;
        s    = cos_q30((p + NINE_N) % ELAS_DEN, 1'b1);
        mag  = (s < 0) ? 64'(-s) : 64'(s);
        prod = (e * mag) >> 30;
        if (s < 0) return clamp_q30($signed(ONE_Q30) - $signed(prod));
        return clamp_q30($signed(ONE_Q30) + $signed(prod));
    endfunction

    function automatic t_rom_even build_even(input logic elas);
        t_rom_even r;
        for (int j = 0; j <= TBL_HALF; j++) begin
            r[j] = elas ? elastic_entry(2 * j) : sine_entry(2 * j);
        end
        return r;
    endfunction

    function automatic t_rom_odd build_odd(input logic elas);
        t_rom_odd r;
        for (int j = 0; j < TBL_HALF; j++) begin
            r[j] = elas ? elastic_entry(2 * j + 1) : sine_entry(2 * j + 1);
        end
        return r;
    endfunction

    // Each curve is split into even and odd entries so that the two
    // neighbouring points of one lookup come from different tables.
    localparam t_rom_even SINE_EVEN = build_even(1'b0);
    localparam t_rom_odd  SINE_ODD  = build_odd(1'b0);
    localparam t_rom_even ELAS_EVEN = build_even(1'b1);
    localparam t_rom_odd  ELAS_ODD  = build_odd(1'b1);

endpackage

FILE: src/eci_curve.sv
`timescale 1ns / 1ps

module eci_curve (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eci_pkg::t_curve_req  i_req,
    output eci_pkg::t_curve_rsp  o_rsp
);

    // Stage 1: operand selection and table reads.
    eci_pkg::t_func                   w_func;
    logic [eci_pkg::PROG_W-1:0]       w_u;
    logic [19:0]                      w_t11;
    logic [20:0]                      w_t22;
    logic signed [21:0]               w_d;
    logic [eci_pkg::SQ_OP_W-1:0]      w_dabs;
    logic [21:0]                      w_koff;
    logic [eci_pkg::EASED_W-1:0]      w_bbase;
    logic [eci_pkg::IDX_W-1:0]        w_idx;
    logic [eci_pkg::EVEN_W-1:0]       w_even_idx;
    logic [eci_pkg::ODD_W-1:0]        w_odd_idx;
    logic [eci_pkg::EASED_W-1:0]      w_sine_even;
    logic [eci_pkg::EASED_W-1:0]      w_sine_odd;
    logic [eci_pkg::EASED_W-1:0]      w_elas_even;
    logic [eci_pkg::EASED_W-1:0]      w_elas_odd;

    eci_pkg::t_kind                   n1_kind;
    eci_pkg::t_shift                  n1_sh;
    logic [eci_pkg::EASED_W-1:0]      n1_base;
    logic [eci_pkg::SQ_OP_W-1:0]      n1_op;
    logic [eci_pkg::EASED_W-1:0]      n1_a;
    logic [eci_pkg::EASED_W-1:0]      n1_b;

    logic                             r1_valid;
    eci_pkg::t_kind                   r1_kind;
    eci_pkg::t_shift                  r1_sh;
    logic [eci_pkg::EASED_W-1:0]      r1_base;
    logic [eci_pkg::SQ_OP_W-1:0]      r1_op;
    logic [eci_pkg::PROG_W-1:0]       r1_t;
    logic [eci_pkg::EASED_W-1:0]      r1_a;
    logic [eci_pkg::EASED_W-1:0]      r1_b;
    logic [eci_pkg::FRAC_SH-1:0]      r1_f;

    always_comb begin
        w_func  = eci_pkg::t_func'(i_req.func);
        w_u     = eci_pkg::Q16_ONE - i_req.t;
        w_t11   = 20'(i_req.t) * 20'd11;
        w_t22   = {w_t11, 1'b0};

        // Bounce segment: offset k*65536 and the floor of that arc.
        if (w_t11 < 20'd262144) begin
            w_koff  = 22'd0;
            w_bbase = 17'd0;
        end else if (w_t11 < 20'd524288) begin
            w_koff  = 22'd786432;
            w_bbase = 17'd49152;
        end else if (w_t11 < 20'd655360) begin
            w_koff  = 22'd1179648;
            w_bbase = 17'd61440;
        end else begin
            w_koff  = 22'd1376256;
            w_bbase = 17'd64512;
        end
        w_d    = $signed({1'b0, w_t22}) - $signed(w_koff);
        w_dabs = w_d[21] ? eci_pkg::SQ_OP_W'(-w_d) : eci_pkg::SQ_OP_W'(w_d);

        // At t = 1 the index is the last entry and the fraction is zero, so
        // the wrapped odd index is never weighted.
        w_idx      = i_req.t[eci_pkg::PROG_W-1:eci_pkg::FRAC_SH];
        w_even_idx = w_idx[0] ? w_idx[eci_pkg::IDX_W-1:1] + eci_pkg::EVEN_W'(1)
                              : w_idx[eci_pkg::IDX_W-1:1];
        w_odd_idx  = w_idx[eci_pkg::ODD_W:1];

        w_sine_even = eci_pkg::SINE_EVEN[w_even_idx];
        w_sine_odd  = eci_pkg::SINE_ODD[w_odd_idx];
        w_elas_even = eci_pkg::ELAS_EVEN[w_even_idx];
        w_elas_odd  = eci_pkg::ELAS_ODD[w_odd_idx];

        n1_kind = eci_pkg::K_PASS;
        n1_sh   = eci_pkg::SH_16;
        n1_base = '0;
        n1_op   = eci_pkg::SQ_OP_W'(i_req.t);
        n1_a    = w_idx[0] ? w_sine_odd : w_sine_even;
        n1_b    = w_idx[0] ? w_sine_even : w_sine_odd;

        case (w_func)
            eci_pkg::FN_IN_QUAD: begin
                n1_kind = eci_pkg::K_SQ_ADD;
            end
            eci_pkg::FN_OUT_QUAD: begin
                n1_kind = eci_pkg::K_SQ_SUB;
                n1_op   = eci_pkg::SQ_OP_W'(w_u);
            end
            eci_pkg::FN_IN_OUT_QUAD: begin
                n1_sh = eci_pkg::SH_15;
                if (i_req.t < 17'd32768) begin
                    n1_kind = eci_pkg::K_SQ_ADD;
                end else begin
                    n1_kind = eci_pkg::K_SQ_SUB;
                    n1_op   = eci_pkg::SQ_OP_W'(w_u);
                end
            end
            eci_pkg::FN_OUT_BOUNCE: begin
                n1_kind = eci_pkg::K_SQ_ADD;
                n1_sh   = eci_pkg::SH_22;
                n1_base = w_bbase;
                n1_op   = w_dabs;
            end
            eci_pkg::FN_IN_OUT_SINE: begin
                n1_kind = eci_pkg::K_TABLE;
            end
            eci_pkg::FN_OUT_ELASTIC: begin
                // The endpoints are exact, which is what passing t through gives.
                if (i_req.t != '0 && i_req.t != eci_pkg::Q16_ONE) begin
                    n1_kind = eci_pkg::K_TABLE;
                end
                n1_a = w_idx[0] ? w_elas_odd : w_elas_even;
                n1_b = w_idx[0] ? w_elas_even : w_elas_odd;
            end
            default: begin
                n1_kind = eci_pkg::K_PASS;
            end
        endcase
    end

    // Stage 2: square and interpolation products.
    logic signed [eci_pkg::EASED_W:0]     w_dab;
    logic signed [eci_pkg::ITP_W-1:0]     w_prod;
    logic [eci_pkg::SQ_W-1:0]             n2_sq;
    logic signed [eci_pkg::ITP_W-1:0]     n2_itp;

    logic                                 r2_valid;
    eci_pkg::t_kind                       r2_kind;
    eci_pkg::t_shift                      r2_sh;
    logic [eci_pkg::EASED_W-1:0]          r2_base;
    logic [eci_pkg::PROG_W-1:0]           r2_t;
    logic [eci_pkg::SQ_W-1:0]             r2_sq;
    logic signed [eci_pkg::ITP_W-1:0]     r2_itp;

    // a*(F-f) + b*f is written as a*F + (b-a)*f, which needs one multiplier.
    always_comb begin
        w_dab  = $signed({1'b0, r1_b}) - $signed({1'b0, r1_a});
        w_prod = w_dab * $signed({1'b0, r1_f});
        n2_sq  = r1_op * r1_op;
        n2_itp = w_prod + $signed({2'b00, r1_a, eci_pkg::FRAC_SH'(0)})
               + $signed(eci_pkg::ITP_HALF);
    end

    // Stage 3: rounding and curve selection.
    logic [eci_pkg::SQ_W-1:0]         w_rnd;
    logic [eci_pkg::EASED_W-1:0]      w_sqr;
    logic [eci_pkg::EASED_W-1:0]      w_tbl;
    logic [eci_pkg::EASED_W-1:0]      w_e;
    logic [eci_pkg::EASED_W-1:0]      n3_eased;
    logic                             r3_valid;
    logic [eci_pkg::EASED_W-1:0]      r3_eased;

    always_comb begin
        w_rnd = r2_sq;
        w_sqr = '0;
        case (r2_sh)
            eci_pkg::SH_15: begin
                w_rnd = r2_sq + eci_pkg::SQ_HALF15;
                w_sqr = w_rnd[15 +: eci_pkg::EASED_W];
            end
            eci_pkg::SH_16: begin
                w_rnd = r2_sq + eci_pkg::SQ_HALF16;
                w_sqr = w_rnd[16 +: eci_pkg::EASED_W];
            end
            eci_pkg::SH_22: begin
                w_rnd = r2_sq + eci_pkg::SQ_HALF22;
                w_sqr = w_rnd[22 +: eci_pkg::EASED_W];
            end
            default: begin
                w_sqr = '0;
            end
        endcase

        w_tbl = r2_itp[eci_pkg::FRAC_SH +: eci_pkg::EASED_W];

        case (r2_kind)
            eci_pkg::K_PASS:   w_e = r2_t;
            eci_pkg::K_SQ_ADD: w_e = r2_base + w_sqr;
            eci_pkg::K_SQ_SUB: w_e = eci_pkg::Q16_ONE - w_sqr;
            eci_pkg::K_TABLE:  w_e = w_tbl;
            default:           w_e = r2_t;
        endcase

        n3_eased = (w_e > eci_pkg::EASED_MAX) ? eci_pkg::EASED_MAX : w_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_req.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind  <= n1_kind;
        r1_sh    <= n1_sh;
        r1_base  <= n1_base;
        r1_op    <= n1_op;
        r1_t     <= i_req.t;
        r1_a     <= n1_a;
        r1_b     <= n1_b;
        r1_f     <= i_req.t[eci_pkg::FRAC_SH-1:0];

        r2_kind  <= r1_kind;
        r2_sh    <= r1_sh;
        r2_base  <= r1_base;
        r2_t     <= r1_t;
        r2_sq    <= n2_sq;
        r2_itp   <= n2_itp;

        r3_eased <= n3_eased;
    end

    assign o_rsp.valid = r3_valid;
    assign o_rsp.eased = r3_eased;

endmodule

FILE: src/easing_curve_interpolator_top.sv
`timescale 1ns / 1ps

// Easing curve evaluator with a linear blend.
// Input: raise start with an item on i_item (curve selector, progress t in
// Q1.16, start and target values). The item is transferred at a rising edge
// where start is high and busy is low; busy is always low, so one item can
// be transferred every cycle with no gaps.
// Output: each item gives one result on o_result, marked by o_done for a
// single cycle. The result passes through each pipeline stage below and is
// taken at the edge that ends the o_done strobe. Results leave in input
// order.
// Throughput is one item per cycle; the pipeline is six register stages
// (input capture, three curve stages, the blend multiply, the saturating
// output) and every stage advances each cycle.
// The receiver has no way to hold results back, so nothing in the pipeline
// ever waits.
// Reset (synchronous, active low) empties the pipeline; items in flight are
// dropped and o_done stays low until new items arrive. The curve tables are
// constants and need no initialisation.
module easing_curve_interpolator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  eci_pkg::t_in_item   i_item,
    output logic                o_done,
    output eci_pkg::t_out_item  o_result
);

    logic                                 w_take;
    logic [eci_pkg::PROG_W-1:0]           w_t;

    // Input capture stage.
    logic                                 r_a_valid;
    logic [eci_pkg::FUNC_W-1:0]           r_a_func;
    logic [eci_pkg::PROG_W-1:0]           r_a_t;
    logic signed [eci_pkg::VAL_W-1:0]     r_a_start;
    logic signed [eci_pkg::DIFF_W-1:0]    r_a_diff;

    eci_pkg::t_curve_req                  w_req;
    eci_pkg::t_curve_rsp                  w_rsp;

    // Side data waiting for the curve unit.
    logic signed [eci_pkg::VAL_W-1:0]     r_dly_start [0:eci_pkg::CURVE_LAT-1];
    logic signed [eci_pkg::DIFF_W-1:0]    r_dly_diff  [0:eci_pkg::CURVE_LAT-1];

    // Blend multiply stage.
    logic signed [34:0]                   w_mul;
    logic signed [35:0]                   n_b_prod;
    logic                                 r_b_valid;
    logic signed [35:0]                   r_b_prod;
    logic [eci_pkg::EASED_W-1:0]          r_b_eased;
    logic signed [eci_pkg::VAL_W-1:0]     r_b_start;

    // Output stage.
    logic signed [19:0]                   w_q;
    logic signed [20:0]                   w_sum;
    logic signed [eci_pkg::VAL_W-1:0]     n_blend;
    logic                                 r_done;
    eci_pkg::t_out_item                   r_out;

    assign busy   = 1'b0;
    assign w_take = start && !busy;
    assign w_t    = (i_item.progress > eci_pkg::Q16_ONE) ? eci_pkg::Q16_ONE
                                                         : i_item.progress;

    assign w_req.valid = r_a_valid;
    assign w_req.func  = r_a_func;
    assign w_req.t     = r_a_t;

    eci_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_mul    = r_dly_diff[eci_pkg::CURVE_LAT-1] * $signed({1'b0, w_rsp.eased});
        n_b_prod = {w_mul[34], w_mul} + 36'sd32768;

        // An arithmetic shift floors, matching the rounding of the blend.
        w_q   = r_b_prod[35:16];
        w_sum = {{5{r_b_start[eci_pkg::VAL_W-1]}}, r_b_start} + {w_q[19], w_q};
        if (w_sum > 21'sd32767) begin
            n_blend = 16'sh7FFF;
        end else if (w_sum < -21'sd32768) begin
            n_blend = 16'sh8000;
        end else begin
            n_blend = w_sum[eci_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_valid <= w_take;
            r_b_valid <= w_rsp.valid;
            r_done    <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_func  <= i_item.func;
        r_a_t     <= w_t;
        r_a_start <= i_item.start_value;
        r_a_diff  <= {i_item.target_value[eci_pkg::VAL_W-1], i_item.target_value}
                   - {i_item.start_value[eci_pkg::VAL_W-1], i_item.start_value};

        r_dly_start[0] <= r_a_start;
        r_dly_diff[0]  <= r_a_diff;
        for (int i = 1; i < eci_pkg::CURVE_LAT; i++) begin
            r_dly_start[i] <= r_dly_start[i-1];
            r_dly_diff[i]  <= r_dly_diff[i-1];
        end

        r_b_prod  <= n_b_prod;
        r_b_eased <= w_rsp.eased;
        r_b_start <= r_dly_start[eci_pkg::CURVE_LAT-1];

        r_out.eased_factor  <= r_b_eased;
        r_out.blended_value <= n_blend;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_done)
        else $error("result strobe missing six cycles after a transfer");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 6))
        else $error("result strobe without a matching input transfer");

    a_eased_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.eased_factor <= eci_pkg::EASED_MAX))
        else $error("eased factor above its ceiling");

    a_flat_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_item.start_value, 6) == $past(i_item.target_value, 6)))
        |-> (o_result.blended_value == $past(i_item.start_value, 6)))
        else $error("equal endpoints did not blend to the start value");

    a_elastic_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_item.func, 6) == eci_pkg::FN_OUT_ELASTIC)
                && ($past(i_item.progress, 6) == 17'd0))
        |-> (o_result.eased_factor == 17'd0))
        else $error("elastic curve not exactly zero at the origin");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import eci_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 6;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          FRAC_SPAN    = 1 << FRAC_SH;
    localparam logic [63:0] Q30_UNIT     = 64'd1073741824;
    localparam logic [63:0] PI_FIX       = 64'd3373259426;
    localparam logic [63:0] LN2_FIX      = 64'd744261118;
    localparam longint      BLEND_MAX    = 32767;
    localparam longint      BLEND_MIN    = -32768;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_item   i_item  = '0;
    logic       o_done;
    t_out_item  o_result;

    logic [EASED_W-1:0] sine_pts    [0:TBL_N];
    logic [EASED_W-1:0] elastic_pts [0:TBL_N];

    t_out_item awaited_blends [$];
    int        mismatches  = 0;
    int        cycle_count = 0;

    easing_curve_interpolator_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[easing_curve_interpolator_top] ERROR");
            $finish;
        end
    end

    // Cosine of 2*pi*num/den in Q30, folded into the first quadrant.
    function automatic longint cos_fix(input logic [63:0] num_in, input logic [63:0] den);
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        bit          flip;
        num  = num_in;
        flip = 1'b0;
        if (2 * num > den) num = den - num;
        if (4 * num > den) begin
            num  = den / 2 - num;
            flip = 1'b1;
        end
        x    = (num * 2 * PI_FIX + den / 2) / den;
        x2   = (x * x) >> 30;
        term = Q30_UNIT;
        acc  = longint'(Q30_UNIT);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return flip ? -acc : acc;
    endfunction

    function automatic logic [63:0] exp_neg_fix(input logic [63:0] y);
        logic [63:0] term;
        longint      acc;
        term = Q30_UNIT;
        acc  = longint'(Q30_UNIT);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic [EASED_W-1:0] q30_to_eased(input longint v);
        logic [63:0] q;
        if (v <= 0) return '0;
        q = (64'(v) + 64'd8192) >> 14;
        if (q > 64'(EASED_MAX)) return EASED_MAX;
        return q[EASED_W-1:0];
    endfunction

    function automatic void build_curve_points();
        logic [63:0] rem;
        logic [63:0] decay;
        logic [63:0] phase;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      c;
        longint      s;
        for (int i = 0; i <= TBL_N; i++) begin
            c            = cos_fix(64'(i), 64'(2 * TBL_N));
            sine_pts[i]  = q30_to_eased((longint'(Q30_UNIT) - c) / 2);
            rem          = 64'(10 * i) & 64'(TBL_N - 1);
            decay        = exp_neg_fix((rem * LN2_FIX + 64'(TBL_N / 2)) >> CURVE_TABLE_BITS)
                           >> ((10 * i) >> CURVE_TABLE_BITS);
            phase        = 64'((40 * i + 9 * TBL_N) % (12 * TBL_N));
            s            = cos_fix((phase + 64'(9 * TBL_N)) % 64'(12 * TBL_N),
                                   64'(12 * TBL_N));
            mag          = (s < 0) ? 64'(-s) : 64'(s);
            prod         = (decay * mag) >> 30;
            elastic_pts[i] = q30_to_eased((s < 0) ? longint'(Q30_UNIT) - longint'(prod)
                                                  : longint'(Q30_UNIT) + longint'(prod));
        end
    endfunction

    function automatic logic [63:0] square_round(input logic [63:0] v, input int sh);
        return (v * v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] curve_point(input bit elastic, input logic [PROG_W-1:0] t);
        int          idx;
        logic [63:0] f;
        logic [63:0] lo;
        logic [63:0] hi;
        idx = int'(t >> FRAC_SH);
        if (idx >= TBL_N) return elastic ? 64'(elastic_pts[TBL_N]) : 64'(sine_pts[TBL_N]);
        f  = 64'(t) & 64'(FRAC_SPAN - 1);
        lo = elastic ? 64'(elastic_pts[idx])     : 64'(sine_pts[idx]);
        hi = elastic ? 64'(elastic_pts[idx + 1]) : 64'(sine_pts[idx + 1]);
        return (lo * (64'(FRAC_SPAN) - f) + hi * f + 64'(FRAC_SPAN / 2)) >> FRAC_SH;
    endfunction

    function automatic logic [63:0] bounce_curve(input logic [PROG_W-1:0] t);
        logic [63:0] t11;
        longint      d;
        longint      k;
        logic [63:0] base;
        t11 = 64'(t) * 11;
        if (t11 < 64'(4 * 65536)) begin
            k = 0;  base = 64'd0;
        end else if (t11 < 64'(8 * 65536)) begin
            k = 12; base = 64'd49152;
        end else if (t11 < 64'(10 * 65536)) begin
            k = 18; base = 64'd61440;
        end else begin
            k = 21; base = 64'd64512;
        end
        d = 22 * longint'(t) - k * 65536;
        if (d < 0) d = -d;
        return base + square_round(64'(d), 22);
    endfunction

    function automatic t_out_item eased_blend(input t_in_item it);
        logic [PROG_W-1:0] t;
        logic [63:0]       u;
        logic [63:0]       e;
        longint            prod;
        longint            sum;
        t_out_item         res;
        t = (it.progress > Q16_ONE) ? Q16_ONE : it.progress;
        u = 64'(Q16_ONE) - 64'(t);
        case (t_func'(it.func))
            FN_IN_QUAD:     e = square_round(64'(t), 16);
            FN_OUT_QUAD:    e = 64'(Q16_ONE) - square_round(u, 16);
            FN_IN_OUT_QUAD: e = (t < 17'd32768) ? square_round(64'(t), 15)
                                                : 64'(Q16_ONE) - square_round(u, 15);
            FN_OUT_BOUNCE:  e = bounce_curve(t);
            FN_IN_OUT_SINE: e = curve_point(1'b0, t);
            FN_OUT_ELASTIC: begin
                // The curve is pinned to its exact end points.
                if (t == '0) e = 64'd0;
                else if (t == Q16_ONE) e = 64'(Q16_ONE);
                else e = curve_point(1'b1, t);
            end
            default:        e = 64'(t);
        endcase
        if (e > 64'(EASED_MAX)) e = 64'(EASED_MAX);
        prod = (longint'($signed(it.target_value)) - longint'($signed(it.start_value)))
               * longint'(e) + 32768;
        sum  = longint'($signed(it.start_value)) + (prod >>> 16);
        if (sum > BLEND_MAX) sum = BLEND_MAX;
        if (sum < BLEND_MIN) sum = BLEND_MIN;
        res.eased_factor  = e[EASED_W-1:0];
        res.blended_value = sum[VAL_W-1:0];
        return res;
    endfunction

    // Expectations are recorded at the accepting edge and compared in order.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n) begin
            if (start && !busy) awaited_blends = {awaited_blends, eased_blend(i_item)};
            if (o_done) begin
                if (awaited_blends.size() == 0) begin
                    $error("unexpected result: eased_factor %0d, blended_value %0d",
                           o_result.eased_factor, $signed(o_result.blended_value));
                    mismatches++;
                end else begin
                    want = awaited_blends.pop_front();
                    if (o_result.eased_factor !== want.eased_factor) begin
                        $error("eased_factor: expected %0d, actual %0d",
                               want.eased_factor, o_result.eased_factor);
                        mismatches++;
                    end
                    if (o_result.blended_value !== want.blended_value) begin
                        $error("blended_value: expected %0d, actual %0d",
                               $signed(want.blended_value), $signed(o_result.blended_value));
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_item(input t_func fn, input logic [PROG_W-1:0] prog,
                                           input logic signed [VAL_W-1:0] sv,
                                           input logic signed [VAL_W-1:0] gv);
        t_in_item it;
        it.func         = fn;
        it.progress     = prog;
        it.start_value  = sv;
        it.target_value = gv;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh8000;
        if (r == 1) return 16'sh7FFF;
        if (r == 2) return '0;
        return VAL_W'($urandom);
    endfunction

    function automatic logic [PROG_W-1:0] random_progress();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return Q16_ONE;
        if (r == 2) return PROG_W'($urandom_range(65537, 131071));
        if (r == 3) return PROG_W'($urandom);
        return PROG_W'($urandom_range(0, 65536));
    endfunction

    // Called just after a rising edge; returns at the transfer edge, or after the idle gap with start low.
    task automatic send_item(input t_in_item it, input int gap);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_blends.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_func fn;
        int    bounce_edges [6] = '{23831, 23832, 47662, 47663, 59578, 59579};
        fn = fn.first();
        do begin
            send_item(make_item(fn, 17'd32768, -16'sd1000, 16'sd1000), pick_gap());
            fn = fn.next();
        end while (fn != fn.first());
        send_item(make_item(FN_OUT_ELASTIC, '0, -16'sd1000, 16'sd1000), 0);
        send_item(make_item(FN_OUT_ELASTIC, Q16_ONE, -16'sd1000, 16'sd1000), 0);
        send_item(make_item(FN_OUT_ELASTIC, 17'd1, -16'sd1000, 16'sd1000), 1);
        send_item(make_item(FN_IN_QUAD, 17'h1FFFF, 16'sh8000, 16'sh7FFF), 0);
        send_item(make_item(FN_IN_OUT_SINE, 17'd65537, 16'sd5, -16'sd5), 2);
        // Elastic blends across the full range, in both directions.
        send_item(make_item(FN_OUT_ELASTIC, 17'd4915, 16'sh8000, 16'sh7FFF), 0);
        send_item(make_item(FN_OUT_ELASTIC, 17'd4915, 16'sh7FFF, 16'sh8000), 0);
        foreach (bounce_edges[i])
            send_item(make_item(FN_OUT_BOUNCE, PROG_W'(bounce_edges[i]),
                                16'sh8000, 16'sh7FFF), pick_gap());
    endtask

    task automatic test_rom_sweep();
        logic [PROG_W-1:0] prog;
        foreach (sine_pts[i]) begin
            prog = PROG_W'(i << FRAC_SH);
            if (i < TBL_N) prog = prog + PROG_W'($urandom_range(0, FRAC_SPAN - 1));
            send_item(make_item(FN_IN_OUT_SINE, prog, random_value(), random_value()),
                      ($urandom_range(0, 3) == 0) ? pick_gap() : 0);
            send_item(make_item(FN_OUT_ELASTIC, prog, random_value(), random_value()),
                      ($urandom_range(0, 3) == 0) ? pick_gap() : 0);
        end
    endtask

    task automatic test_burst(input int count);
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            it          = make_item(t_func'($urandom_range(0, 7)), random_progress(),
                                    random_value(), random_value());
            send_item(it, 0);
        end
    endtask

    task automatic test_random(input int count);
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            it = make_item(t_func'($urandom_range(0, 7)), random_progress(),
                           random_value(), random_value());
            send_item(it, pick_gap());
        end
    endtask

    initial begin
        build_curve_points();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drain();
        test_rom_sweep();
        wait_drain();
        test_burst(200);
        wait_drain();
        test_random(900);
        wait_drain();
        if (mismatches == 0 && awaited_blends.size() == 0)
            $display("[easing_curve_interpolator_top] OK");
        else
            $display("[easing_curve_interpolator_top] ERROR");
        $finish;
    end

endmodule
